FILE: sv/nvs_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the nearest vertex search block.
// Depends on nothing; the other files of the block, except nvs_ram, refer to it by scoped names.
package nvs_pkg;

    localparam int COMMAND_W = 1;
    localparam int SLOT_W    = 12;
    localparam int COORD_W   = 16;
    localparam int IDX_W     = 12;
    localparam int DIST_W    = 34;
    localparam int COUNT_W   = 13;

    localparam logic [COMMAND_W-1:0] CMD_LOAD  = 1'b0;
    localparam logic [COMMAND_W-1:0] CMD_QUERY = 1'b1;

    // Saturated distance, also the starting best distance of a search.
    localparam logic [DIST_W-1:0] DIST_MAX = {DIST_W{1'b1}};

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_RUN   = 4'b0010,
        ST_DRAIN = 4'b0100,
        ST_HOLD  = 4'b1000
    } nvs_state_t;

endpackage

FILE: sv/nvs_in_if.sv
`timescale 1ns / 1ps
// Command channel of the nearest vertex search block: valid, ready and one command item.
// Depends on nvs_pkg for the field widths.
interface nvs_in_if;

    logic                                valid;
    logic                                ready;
    logic [nvs_pkg::COMMAND_W-1:0]       command;
    logic [nvs_pkg::SLOT_W-1:0]          vertex_slot;
    logic signed [nvs_pkg::COORD_W-1:0]  coord_x;
    logic signed [nvs_pkg::COORD_W-1:0]  coord_y;
    logic signed [nvs_pkg::COORD_W-1:0]  coord_z;

    modport source (
        output valid,
        output command,
        output vertex_slot,
        output coord_x,
        output coord_y,
        output coord_z,
        input  ready
    );

    modport sink (
        input  valid,
        input  command,
        input  vertex_slot,
        input  coord_x,
        input  coord_y,
        input  coord_z,
        output ready
    );

endinterface

FILE: sv/nvs_out_if.sv
`timescale 1ns / 1ps
// Result channel of the nearest vertex search block: valid, ready and one result item.
// Depends on nvs_pkg for the field widths.
interface nvs_out_if;

    logic                          valid;
    logic                          ready;
    logic [nvs_pkg::IDX_W-1:0]     nearest_index;
    logic [nvs_pkg::DIST_W-1:0]    nearest_dist_sq;

    modport source (
        output valid,
        output nearest_index,
        output nearest_dist_sq,
        input  ready
    );

    modport sink (
        input  valid,
        input  nearest_index,
        input  nearest_dist_sq,
        output ready
    );

endinterface

FILE: sv/nearest_vertex_search.sv
`timescale 1ns / 1ps
// Top level of the nearest vertex search block: sequencer, vertex store and best-match tracking.
// Depends on nvs_pkg, nvs_in_if, nvs_out_if, nvs_ram and nvs_dist_unit.
//
//  Channel   Direction  Handshake               Payload
//  req       in         req.valid / req.ready   command, vertex_slot, coord_x/y/z
//  rsp       out        rsp.valid / rsp.ready   nearest_index, nearest_dist_sq
//  cfg       in         cfg_we                  cfg_wdata (vertex_count)
//
// A load writes the vertex store directly.
// A query, with vertex_count capped at MAX_VERTICES, reads one store entry per cycle through
// the single read port and feeds it to the three-stage distance unit, then drains that unit
// and loads the output register. With a vertex_count of zero the query skips the read and
// drain steps and goes straight to loading the output register.
// The finished result sits in an output register, so the next transfer on req is taken
// while it waits on rsp; a following query holds in its last cycle until that result has
// been taken. Reset clears the sequencer and the count; the store is not cleared.
module nearest_vertex_search #(
    parameter int MAX_VERTICES = 4096,
    parameter int COORD_BITS   = 16
) (
    input  logic                          clk,
    input  logic                          rst_n,
    nvs_in_if.sink                        req,
    nvs_out_if.source                     rsp,
    input  logic                          cfg_we,
    input  logic [nvs_pkg::COUNT_W-1:0]   cfg_wdata
);

    localparam int ADDR_W = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
    localparam int CNT_W  = $clog2(MAX_VERTICES + 1);
    localparam int RAW_W  = (COORD_BITS > nvs_pkg::COORD_W) ? COORD_BITS : nvs_pkg::COORD_W;
    localparam int VTX_W  = 3 * COORD_BITS;
    localparam logic [CNT_W-1:0] CNT_ONE = CNT_W'(1);

    nvs_pkg::nvs_state_t           state_reg;
    nvs_pkg::nvs_state_t           state_next;
    logic [nvs_pkg::COUNT_W-1:0]   count_reg;
    logic [nvs_pkg::COUNT_W-1:0]   count_next;
    logic [CNT_W-1:0]              n_reg;
    logic [CNT_W-1:0]              n_next;
    logic [CNT_W-1:0]              addr_reg;
    logic [CNT_W-1:0]              addr_next;
    logic [VTX_W-1:0]              query_reg;
    logic [VTX_W-1:0]              query_next;
    logic                          rd_valid_reg;
    logic [ADDR_W-1:0]             rd_idx_reg;
    logic [nvs_pkg::DIST_W-1:0]    best_dist_reg;
    logic [nvs_pkg::DIST_W-1:0]    best_dist_next;
    logic [ADDR_W-1:0]             best_idx_reg;
    logic [ADDR_W-1:0]             best_idx_next;
    logic                          out_valid_reg;
    logic                          out_valid_next;
    logic [nvs_pkg::IDX_W-1:0]     out_idx_reg;
    logic [nvs_pkg::IDX_W-1:0]     out_idx_next;
    logic [nvs_pkg::DIST_W-1:0]    out_dist_reg;
    logic [nvs_pkg::DIST_W-1:0]    out_dist_next;

    logic                          req_fire;
    logic                          rsp_fire;
    logic [RAW_W-1:0]              raw_x;
    logic [RAW_W-1:0]              raw_y;
    logic [RAW_W-1:0]              raw_z;
    logic [VTX_W-1:0]              vtx_in;
    logic [31:0]                   slot_wide;
    logic                          slot_ok;
    logic                          ram_we;
    logic                          ram_re;
    logic [VTX_W-1:0]              ram_rdata;
    logic [31:0]                   count_wide;
    logic [CNT_W-1:0]              n_sat;
    logic [31:0]                   best_idx_wide;
    logic                          d_valid;
    logic [ADDR_W-1:0]             d_idx;
    logic [nvs_pkg::DIST_W-1:0]    d_dist;
    logic                          d_busy;

    assign req_fire = req.valid & req.ready;
    assign rsp_fire = rsp.valid & rsp.ready;

    // The low COORD_BITS bits of each field are taken and read as two's complement.
    assign raw_x  = RAW_W'($unsigned(req.coord_x));
    assign raw_y  = RAW_W'($unsigned(req.coord_y));
    assign raw_z  = RAW_W'($unsigned(req.coord_z));
    assign vtx_in = {raw_z[COORD_BITS-1:0], raw_y[COORD_BITS-1:0], raw_x[COORD_BITS-1:0]};

    assign slot_wide = 32'(req.vertex_slot);
    assign slot_ok   = slot_wide < 32'(MAX_VERTICES);
    assign ram_we    = req_fire && (req.command == nvs_pkg::CMD_LOAD) && slot_ok;
    assign ram_re    = (state_reg == nvs_pkg::ST_RUN);

    assign count_wide    = 32'(count_reg);
    assign n_sat         = (count_wide > 32'(MAX_VERTICES)) ? CNT_W'(MAX_VERTICES)
                                                            : CNT_W'(count_reg);
    assign best_idx_wide = 32'(best_idx_reg);

    nvs_ram #(
        .WIDTH (VTX_W),
        .DEPTH (MAX_VERTICES)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (slot_wide[ADDR_W-1:0]),
        .wdata (vtx_in),
        .re    (ram_re),
        .raddr (addr_reg[ADDR_W-1:0]),
        .rdata (ram_rdata)
    );

    nvs_dist_unit #(
        .COORD_BITS (COORD_BITS),
        .IDX_W      (ADDR_W)
    ) u_dist (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (rd_valid_reg),
        .in_idx    (rd_idx_reg),
        .query     (query_reg),
        .vertex    (ram_rdata),
        .out_valid (d_valid),
        .out_idx   (d_idx),
        .out_dist  (d_dist),
        .busy      (d_busy)
    );

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        n_next         = n_reg;
        addr_next      = addr_reg;
        query_next     = query_reg;
        best_dist_next = best_dist_reg;
        best_idx_next  = best_idx_reg;
        out_valid_next = out_valid_reg;
        out_idx_next   = out_idx_reg;
        out_dist_next  = out_dist_reg;

        if (cfg_we)
        begin
            count_next = cfg_wdata;
        end

        // A strict compare keeps the lowest index on a tie.
        if (d_valid && (d_dist < best_dist_reg))
        begin
            best_dist_next = d_dist;
            best_idx_next  = d_idx;
        end

        if (rsp_fire)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            nvs_pkg::ST_IDLE:
            begin
                if (req_fire && (req.command == nvs_pkg::CMD_QUERY))
                begin
                    query_next     = vtx_in;
                    n_next         = n_sat;
                    addr_next      = '0;
                    best_dist_next = nvs_pkg::DIST_MAX;
                    best_idx_next  = '0;
                    if (n_sat == '0)
                    begin
                        state_next = nvs_pkg::ST_HOLD;
                    end
                    else
                    begin
                        state_next = nvs_pkg::ST_RUN;
                    end
                end
            end
            nvs_pkg::ST_RUN:
            begin
                addr_next = addr_reg + CNT_ONE;
                if (addr_reg == (n_reg - CNT_ONE))
                begin
                    state_next = nvs_pkg::ST_DRAIN;
                end
            end
            nvs_pkg::ST_DRAIN:
            begin
                if (!rd_valid_reg && !d_busy)
                begin
                    state_next = nvs_pkg::ST_HOLD;
                end
            end
            nvs_pkg::ST_HOLD:
            begin
                if (!out_valid_reg || rsp_fire)
                begin
                    out_valid_next = 1'b1;
                    out_idx_next   = best_idx_wide[nvs_pkg::IDX_W-1:0];
                    out_dist_next  = best_dist_reg;
                    state_next     = nvs_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = nvs_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= nvs_pkg::ST_IDLE;
            count_reg     <= '0;
            rd_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            rd_valid_reg  <= ram_re;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        n_reg         <= n_next;
        addr_reg      <= addr_next;
        query_reg     <= query_next;
        rd_idx_reg    <= addr_reg[ADDR_W-1:0];
        best_dist_reg <= best_dist_next;
        best_idx_reg  <= best_idx_next;
        out_idx_reg   <= out_idx_next;
        out_dist_reg  <= out_dist_next;
    end

    assign req.ready           = (state_reg == nvs_pkg::ST_IDLE);
    assign rsp.valid           = out_valid_reg;
    assign rsp.nearest_index   = out_idx_reg;
    assign rsp.nearest_dist_sq = out_dist_reg;

endmodule

FILE: sv/nvs_ram.sv
`timescale 1ns / 1ps
// Generic simple dual-port RAM with one write port and one registered read port.
// Depends on nothing.
module nvs_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 4096
) (
    input  logic                                      clk,
    input  logic                                      we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                          wdata,
    input  logic                                      re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                          rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

FILE: sv/nvs_dist_unit.sv
`timescale 1ns / 1ps
// Three-stage squared distance unit: absolute differences, squares, saturating sum.
// Depends on nvs_pkg for the distance width and its saturation value.
module nvs_dist_unit #(
    parameter int COORD_BITS = 16,
    parameter int IDX_W      = 12
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    input  logic [IDX_W-1:0]              in_idx,
    input  logic [3*COORD_BITS-1:0]       query,
    input  logic [3*COORD_BITS-1:0]       vertex,
    output logic                          out_valid,
    output logic [IDX_W-1:0]              out_idx,
    output logic [nvs_pkg::DIST_W-1:0]    out_dist,
    output logic                          busy
);

    localparam int MAG_W  = COORD_BITS + 1;
    localparam int SQ_W   = 2 * MAG_W;
    localparam int SUM_W  = SQ_W + 2;
    localparam int WIDE_W = (SUM_W > nvs_pkg::DIST_W + 1) ? SUM_W : nvs_pkg::DIST_W + 1;

    logic signed [COORD_BITS-1:0] q_c [3];
    logic signed [COORD_BITS-1:0] v_c [3];
    logic signed [MAG_W-1:0]      diff [3];
    logic [MAG_W-1:0]             mag_next [3];
    logic [MAG_W-1:0]             mag_reg [3];
    logic [SQ_W-1:0]              sq_next [3];
    logic [SQ_W-1:0]              sq_reg [3];
    logic [WIDE_W-1:0]            sum_wide;
    logic [nvs_pkg::DIST_W-1:0]   dist_next;
    logic [nvs_pkg::DIST_W-1:0]   dist_reg;
    logic                         v1_reg;
    logic                         v2_reg;
    logic                         v3_reg;
    logic [IDX_W-1:0]             idx1_reg;
    logic [IDX_W-1:0]             idx2_reg;
    logic [IDX_W-1:0]             idx3_reg;

    for (genvar c = 0; c < 3; c++)
    begin : g_axis
        assign q_c[c]  = $signed(query[c*COORD_BITS +: COORD_BITS]);
        assign v_c[c]  = $signed(vertex[c*COORD_BITS +: COORD_BITS]);
        assign diff[c] = MAG_W'(q_c[c]) - MAG_W'(v_c[c]);
        assign mag_next[c] = diff[c][MAG_W-1] ? MAG_W'($unsigned(-diff[c]))
                                              : MAG_W'($unsigned(diff[c]));
        assign sq_next[c]  = SQ_W'(mag_reg[c]) * SQ_W'(mag_reg[c]);

        always_ff @(posedge clk)
        begin
            mag_reg[c] <= mag_next[c];
            sq_reg[c]  <= sq_next[c];
        end
    end

    always_comb
    begin
        sum_wide = WIDE_W'(sq_reg[0]) + WIDE_W'(sq_reg[1]) + WIDE_W'(sq_reg[2]);
        if (sum_wide > WIDE_W'(nvs_pkg::DIST_MAX))
        begin
            dist_next = nvs_pkg::DIST_MAX;
        end
        else
        begin
            dist_next = sum_wide[nvs_pkg::DIST_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        idx1_reg <= in_idx;
        idx2_reg <= idx1_reg;
        idx3_reg <= idx2_reg;
        dist_reg <= dist_next;
    end

    assign out_valid = v3_reg;
    assign out_idx   = idx3_reg;
    assign out_dist  = dist_reg;
    assign busy      = v1_reg | v2_reg | v3_reg;

endmodule

FILE: test/testbench.sv
`timescale 1ns / 1ps
// Self-checking testbench for nearest_vertex_search: loads vertices, sets the search count and
// checks every query result against a predictor kept in step with each accepted transfer.
// Depends on nvs_pkg, nvs_in_if, nvs_out_if and the nearest_vertex_search RTL.
module testbench;

    localparam int VERTEX_SLOTS = 4096;
    localparam logic signed [nvs_pkg::COORD_W-1:0] COORD_MIN =
        {1'b1, {(nvs_pkg::COORD_W-1){1'b0}}};
    localparam logic signed [nvs_pkg::COORD_W-1:0] COORD_MAX =
        {1'b0, {(nvs_pkg::COORD_W-1){1'b1}}};

    typedef struct {
        logic signed [nvs_pkg::COORD_W-1:0] x;
        logic signed [nvs_pkg::COORD_W-1:0] y;
        logic signed [nvs_pkg::COORD_W-1:0] z;
    } point_t;

    typedef struct {
        logic [nvs_pkg::COMMAND_W-1:0] command;
        logic [nvs_pkg::SLOT_W-1:0]    slot;
        point_t                        pos;
    } vertex_cmd_t;

    typedef struct {
        logic [nvs_pkg::IDX_W-1:0]  index;
        logic [nvs_pkg::DIST_W-1:0] dist_sq;
    } nearest_t;

    logic                          clk = 1'b0;
    logic                          rst_n = 1'b0;
    logic                          cfg_we;
    logic [nvs_pkg::COUNT_W-1:0]   cfg_wdata;

    nvs_in_if  req ();
    nvs_out_if rsp ();

    nearest_vertex_search i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .rsp       (rsp),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    vertex_cmd_t pending_cmds[$];
    nearest_t    expected_hits[$];
    point_t      mesh_store[VERTEX_SLOTS];
    int          search_count;
    point_t      loaded_pos[VERTEX_SLOTS];
    bit          slot_written[VERTEX_SLOTS];
    int          mismatch_count;
    bit          no_idle;
    bit          req_fire;
    bit          rsp_fire;
    bit          sending;
    int          send_gap;
    int          hold_left;
    vertex_cmd_t cur_cmd;

    function automatic int draw_wait();
        return no_idle ? 0 : int'($urandom_range(0, 11));
    endfunction

    function automatic logic signed [nvs_pkg::COORD_W-1:0] pick_coord();
        case ($urandom_range(0, 7))
            0: return COORD_MIN;
            1: return COORD_MAX;
            2: return nvs_pkg::COORD_W'(int'($urandom_range(0, 63)) - 32);
            default: return nvs_pkg::COORD_W'($urandom());
        endcase
    endfunction

    function automatic nearest_t search_nearest(point_t q);
        nearest_t best;
        int       n;
        longint   dx;
        longint   dy;
        longint   dz;
        longint   d;
        best.index   = '0;
        best.dist_sq = nvs_pkg::DIST_MAX;
        n = (search_count > VERTEX_SLOTS) ? VERTEX_SLOTS : search_count;
        for (int i = 0; i < n; i++)
        begin
            dx = longint'(q.x) - longint'(mesh_store[i].x);
            dy = longint'(q.y) - longint'(mesh_store[i].y);
            dz = longint'(q.z) - longint'(mesh_store[i].z);
            d  = dx * dx + dy * dy + dz * dz;
            if (d > longint'(nvs_pkg::DIST_MAX))
                d = longint'(nvs_pkg::DIST_MAX);
            if (i == 0 || d < longint'(best.dist_sq))
            begin
                best.dist_sq = nvs_pkg::DIST_W'(d);
                best.index   = nvs_pkg::IDX_W'(i);
            end
        end
        return best;
    endfunction

    task automatic report_mismatch(string what, longint want, longint got);
        mismatch_count++;
        if (mismatch_count <= 10)
            $display("%0t: %s mismatch: expected %0d, got %0d", $time, what, want, got);
    endtask

    task automatic queue_load(int slot, logic signed [nvs_pkg::COORD_W-1:0] x,
                              logic signed [nvs_pkg::COORD_W-1:0] y,
                              logic signed [nvs_pkg::COORD_W-1:0] z);
        vertex_cmd_t c;
        c.command = nvs_pkg::CMD_LOAD;
        c.slot    = nvs_pkg::SLOT_W'(slot);
        c.pos     = '{x, y, z};
        pending_cmds = {pending_cmds, c};
        slot_written[slot] = 1'b1;
        loaded_pos[slot]   = c.pos;
    endtask

    task automatic queue_query(logic signed [nvs_pkg::COORD_W-1:0] x,
                               logic signed [nvs_pkg::COORD_W-1:0] y,
                               logic signed [nvs_pkg::COORD_W-1:0] z);
        vertex_cmd_t c;
        c.command = nvs_pkg::CMD_QUERY;
        c.slot    = nvs_pkg::SLOT_W'($urandom());
        c.pos     = '{x, y, z};
        pending_cmds = {pending_cmds, c};
    endtask

    task automatic settle();
        while (pending_cmds.size() != 0 || sending || expected_hits.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic write_count(int n);
        settle();
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= nvs_pkg::COUNT_W'(n);
        @(negedge clk);
        cfg_we    <= 1'b0;
        search_count = n & ((1 << nvs_pkg::COUNT_W) - 1);
    endtask

    task automatic run_round(int n, int items, bit hold_midway);
        int     slot;
        point_t p;
        for (int s = 0; s < n; s++)
        begin
            if (!slot_written[s] || $urandom_range(0, 3) == 0)
                queue_load(s, pick_coord(), pick_coord(), pick_coord());
        end
        repeat (2) queue_load($urandom_range(0, VERTEX_SLOTS - 1), pick_coord(), pick_coord(),
                              pick_coord());
        write_count(n);
        for (int k = 0; k < items; k++)
        begin
            if (hold_midway && k == items / 2)
            begin
                while (pending_cmds.size() != 0 || sending || expected_hits.size() != 0)
                    @(posedge clk);
            end
            case ($urandom_range(0, 9))
                0:
                begin
                    slot = $urandom_range(0, 1) ? $urandom_range(0, n - 1)
                                                : $urandom_range(0, VERTEX_SLOTS - 1);
                    queue_load(slot, pick_coord(), pick_coord(), pick_coord());
                end
                1:
                begin
                    p = loaded_pos[$urandom_range(0, n - 1)];
                    queue_load($urandom_range(0, n - 1), p.x, p.y, p.z);
                end
                2, 3, 4:
                begin
                    p = loaded_pos[$urandom_range(0, n - 1)];
                    queue_query(p.x + nvs_pkg::COORD_W'(int'($urandom_range(0, 6)) - 3),
                                p.y + nvs_pkg::COORD_W'(int'($urandom_range(0, 6)) - 3),
                                p.z + nvs_pkg::COORD_W'(int'($urandom_range(0, 6)) - 3));
                end
                default: queue_query(pick_coord(), pick_coord(), pick_coord());
            endcase
        end
    endtask

    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (sending && req_fire)
                sending = 1'b0;
            if (!sending)
            begin
                if (send_gap > 0)
                    send_gap = send_gap - 1;
                else if (pending_cmds.size() != 0)
                begin
                    cur_cmd  = pending_cmds.pop_front();
                    sending  = 1'b1;
                    send_gap = draw_wait();
                end
            end
            req.valid       <= sending;
            req.command     <= cur_cmd.command;
            req.vertex_slot <= cur_cmd.slot;
            req.coord_x     <= cur_cmd.pos.x;
            req.coord_y     <= cur_cmd.pos.y;
            req.coord_z     <= cur_cmd.pos.z;
        end
    end

    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (rsp_fire)
                hold_left = draw_wait();
            if (hold_left > 0 && rsp.valid)
                hold_left = hold_left - 1;
            rsp.ready <= (hold_left == 0);
        end
    end

    always @(posedge clk)
    begin
        req_fire <= rst_n && req.valid && req.ready;
        if (rst_n && req.valid && req.ready)
        begin
            if (req.command == nvs_pkg::CMD_LOAD)
                mesh_store[req.vertex_slot] = '{req.coord_x, req.coord_y, req.coord_z};
            else
                expected_hits = {expected_hits,
                                 search_nearest('{req.coord_x, req.coord_y, req.coord_z})};
        end
    end

    always @(posedge clk)
    begin : result_check
        nearest_t want;
        rsp_fire <= rst_n && rsp.valid && rsp.ready;
        if (rst_n && rsp.valid && rsp.ready)
        begin
            if (expected_hits.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("%0t: result transfer with no query outstanding: index %0d, dist %0d",
                             $time, rsp.nearest_index, rsp.nearest_dist_sq);
            end
            else
            begin
                want = expected_hits.pop_front();
                if (rsp.nearest_index !== want.index)
                    report_mismatch("nearest_index", want.index, rsp.nearest_index);
                if (rsp.nearest_dist_sq !== want.dist_sq)
                    report_mismatch("nearest_dist_sq", want.dist_sq, rsp.nearest_dist_sq);
            end
        end
    end

    initial
    begin : clock_gen
        forever #1 clk = ~clk;
    end

    initial
    begin : watchdog
        #2_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

    initial
    begin : stimulus
        int n;
        req.valid       = 1'b0;
        req.command     = nvs_pkg::CMD_LOAD;
        req.vertex_slot = '0;
        req.coord_x     = '0;
        req.coord_y     = '0;
        req.coord_z     = '0;
        rsp.ready       = 1'b0;
        cfg_we          = 1'b0;
        cfg_wdata       = '0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // An empty search returns index 0 and a saturated distance.
        write_count(0);
        queue_query(0, 0, 0);
        queue_query(COORD_MIN, COORD_MAX, -1);

        queue_load(0, COORD_MIN, COORD_MIN, COORD_MIN);
        queue_load(1, COORD_MAX, COORD_MAX, COORD_MAX);
        queue_load(2, 0, 0, 0);
        queue_load(3, 0, 0, 0);
        queue_load(4, 16, 0, 0);
        queue_load(VERTEX_SLOTS - 1, COORD_MAX, COORD_MIN, 0);
        write_count(1);
        queue_query(COORD_MAX, COORD_MAX, COORD_MAX);

        // Identical and equidistant vertices must resolve to the lower index.
        write_count(5);
        queue_query(COORD_MAX, COORD_MAX, COORD_MAX);
        queue_query(COORD_MIN, COORD_MIN, COORD_MIN);
        queue_query(0, 0, 0);
        queue_query(8, 0, 0);
        queue_query(-1, -1, -1);
        queue_query(COORD_MAX, COORD_MIN, 0);

        for (int r = 0; r < 7; r++)
        begin
            n = (r == 0) ? 1 : (r == 1) ? 2 : (r == 6) ? 40 : int'($urandom_range(3, 24));
            no_idle = (r == 3);
            run_round(n, 10, r == 2);
        end
        no_idle = 1'b0;

        write_count(0);
        queue_query(pick_coord(), pick_coord(), pick_coord());

        settle();
        repeat (12) @(posedge clk);
        if (mismatch_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
